/* src/hpi_pkg.sv */
// Package for the half-pel six-tap interpolator: constants, register codes and payload types.
package hpi_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int TAP_ROWS  = 5;
    localparam int PIX_W     = 8;
    localparam int COL_AW    = $clog2(MAX_WIDTH);
    localparam int WORD_W    = TAP_ROWS * PIX_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOR_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOR_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VER_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VER_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIA_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DIA_HEIGHT    = 3'd7;

    typedef struct packed {
        logic [7:0] pixel;
        logic       window_start;
    } in_t;

    typedef struct packed {
        logic [4:0] in_row;
        logic [4:0] in_col;
        logic       hor_valid;
        logic [7:0] hor_sample;
        logic       ver_valid;
        logic [7:0] ver_sample;
        logic       dia_valid;
        logic [7:0] dia_sample;
        logic       window_last;
    } out_t;

endpackage

/* src/hpi_ram.sv */
// Generic simple dual-port RAM with a registered, read-first read port.
module hpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/half_pel_six_tap_interpolator.sv */
// Top level of the half-pel six-tap interpolator with its two column-word line stores.
//
// The block takes reference window pixels in raster order on the s_ channel and
// returns one result transaction per pixel on the m_ channel: the pixel position,
// the horizontal, vertical and diagonal half-pel samples with their valid flags,
// and a flag on the last pixel of the window. A set window_start places the pixel
// at row 0, column 0. Registers are to be written through cfg_write_en, cfg_index
// and cfg_data only while the block is idle; the block itself does not enforce this.
// Each line store holds one word per column with all five stored rows side by side;
// a pixel reads its column word at acceptance and writes the updated word back when
// it leaves the filter stage, with forwarding when the next pixel hits the same column.
// A result moves from the filter stage register into the output register, where it
// is held until the receiver takes it.
// One pixel is accepted every cycle while the receiver does not stall, limited by the
// single read-modify-write of each line store per cycle.
// When the receiver stalls, one result waits in the output register and one in the
// filter stage, so s_ready drops only when both are occupied.
// Reset empties the pipeline, returns the registers to their defaults and clears
// the position and the row taps; the line stores need no clearing pass.
module half_pel_six_tap_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  hpi_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output hpi_pkg::out_t                       m_data,
    input  logic                                cfg_write_en,
    input  logic [hpi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hpi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef struct packed {
        logic [4:0]                     row;
        logic [4:0]                     col;
        logic [2:0]                     slot;
        logic [7:0]                     pixel;
        logic [7:0]                     hor;
        logic                           hv;
        logic                           vv;
        logic                           dv;
        logic                           last;
        logic                           o_in_range;
        logic                           h_in_range;
        logic                           o_fwd;
        logic                           h_fwd;
        logic [hpi_pkg::WORD_W-1:0]     o_fwd_word;
        logic [hpi_pkg::WORD_W-1:0]     h_fwd_word;
    } stage_t;

    function automatic logic [7:0] six_tap(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d,
                                           input logic [7:0] e, input logic [7:0] f);
        logic signed [14:0] sum;
        logic [9:0]         q;
        sum = $signed({7'd0, a}) + $signed({7'd0, f})
            + 15'sd20 * ($signed({7'd0, c}) + $signed({7'd0, d}))
            - 15'sd5 * ($signed({7'd0, b}) + $signed({7'd0, e})) + 15'sd16;
        q = sum[14:5];
        if (sum[14]) begin
            return 8'd0;
        end else if (q > 10'd255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic logic [2:0] slot_add(input logic [2:0] s, input int k);
        logic [3:0] t;
        t = 4'(s) + 4'(k);
        if (t >= 4'(hpi_pkg::TAP_ROWS)) begin
            t = t - 4'(hpi_pkg::TAP_ROWS);
        end
        return t[2:0];
    endfunction

    logic [5:0] window_width_reg, window_height_reg, hor_height_reg;
    logic [4:0] hor_width_reg, ver_width_reg, ver_height_reg, dia_width_reg, dia_height_reg;

    logic [4:0] row_pos_reg, col_pos_reg;
    logic [2:0] slot_reg;
    logic [7:0] tap_reg [hpi_pkg::TAP_ROWS];

    logic          st_valid_reg;
    stage_t        st_reg;
    stage_t        st_next;
    logic          m_valid_reg;
    hpi_pkg::out_t m_data_reg;
    hpi_pkg::out_t out_next;

    logic accept, advance;
    logic [4:0] r1, c1;
    logic [2:0] s1;
    logic last_col, last_row;
    logic [4:0] row_pos_next, col_pos_next;
    logic [2:0] slot_next;

    logic                        o_we, h_we;
    logic [hpi_pkg::COL_AW-1:0]  o_waddr, h_waddr, o_raddr, h_raddr;
    logic [hpi_pkg::WORD_W-1:0]  o_wdata, h_wdata, o_rdata, h_rdata;
    logic [hpi_pkg::WORD_W-1:0]  o_word, h_word;
    logic [7:0]                  o_tap [hpi_pkg::TAP_ROWS];
    logic [7:0]                  h_tap [hpi_pkg::TAP_ROWS];
    logic [4:0]                  st_col_m5;

    assign advance = st_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // Stage one: position, horizontal filter and store reads.
    always_comb begin
        r1 = s_data.window_start ? 5'd0 : row_pos_reg;
        c1 = s_data.window_start ? 5'd0 : col_pos_reg;
        s1 = s_data.window_start ? 3'd0 : slot_reg;
        last_col = ({1'b0, c1} + 6'd1 == window_width_reg) || (c1 == 5'd31);
        last_row = ({1'b0, r1} + 6'd1 == window_height_reg) || (r1 == 5'd31);

        row_pos_next = r1;
        col_pos_next = c1 + 5'd1;
        slot_next    = s1;
        if (last_col) begin
            col_pos_next = 5'd0;
            if (last_row) begin
                row_pos_next = 5'd0;
                slot_next    = 3'd0;
            end else begin
                row_pos_next = r1 + 5'd1;
                slot_next    = slot_add(s1, 1);
            end
        end

        o_raddr = hpi_pkg::COL_AW'(c1);
        h_raddr = hpi_pkg::COL_AW'(c1 - 5'd5);

        st_next.row        = r1;
        st_next.col        = c1;
        st_next.slot       = s1;
        st_next.pixel      = s_data.pixel;
        st_next.hor        = six_tap(tap_reg[0], tap_reg[1], tap_reg[2], tap_reg[3],
                                     tap_reg[4], s_data.pixel);
        st_next.hv         = (c1 >= 5'd5) && ((c1 - 5'd5) < hor_width_reg)
                           && ({1'b0, r1} < hor_height_reg);
        st_next.vv         = (r1 >= 5'd5) && (c1 >= 5'd2) && ((r1 - 5'd5) < ver_height_reg)
                           && ((c1 - 5'd2) < ver_width_reg);
        st_next.dv         = (r1 >= 5'd5) && (c1 >= 5'd5) && ((r1 - 5'd5) < dia_height_reg)
                           && ((c1 - 5'd5) < dia_width_reg);
        st_next.last       = last_col && last_row;
        st_next.o_in_range = int'(c1) < hpi_pkg::MAX_WIDTH;
        st_next.h_in_range = (c1 >= 5'd5) && (int'(c1 - 5'd5) < hpi_pkg::MAX_WIDTH);
        st_next.o_fwd      = o_we && (o_waddr == o_raddr);
        st_next.h_fwd      = h_we && (h_waddr == h_raddr);
        st_next.o_fwd_word = o_wdata;
        st_next.h_fwd_word = h_wdata;
    end

    // Stage two: vertical and diagonal filters and store write-back.
    always_comb begin
        o_word = st_reg.o_fwd ? st_reg.o_fwd_word : o_rdata;
        h_word = st_reg.h_fwd ? st_reg.h_fwd_word : h_rdata;
        if (!st_reg.o_in_range) begin
            o_word = '0;
        end
        if (!st_reg.h_in_range) begin
            h_word = '0;
        end
        for (int k = 0; k < hpi_pkg::TAP_ROWS; k++) begin
            o_tap[k] = o_word[hpi_pkg::PIX_W*slot_add(st_reg.slot, k) +: hpi_pkg::PIX_W];
            h_tap[k] = h_word[hpi_pkg::PIX_W*slot_add(st_reg.slot, k) +: hpi_pkg::PIX_W];
        end

        o_wdata = o_word;
        o_wdata[hpi_pkg::PIX_W*st_reg.slot +: hpi_pkg::PIX_W] = st_reg.pixel;
        h_wdata = h_word;
        h_wdata[hpi_pkg::PIX_W*st_reg.slot +: hpi_pkg::PIX_W] = st_reg.hor;
        st_col_m5 = st_reg.col - 5'd5;
        o_we    = advance && st_reg.o_in_range;
        h_we    = advance && st_reg.h_in_range;
        o_waddr = hpi_pkg::COL_AW'(st_reg.col);
        h_waddr = hpi_pkg::COL_AW'(st_col_m5);

        out_next.in_row      = st_reg.row;
        out_next.in_col      = st_reg.col;
        out_next.hor_valid   = st_reg.hv;
        out_next.hor_sample  = st_reg.hv ? st_reg.hor : 8'd0;
        out_next.ver_valid   = st_reg.vv;
        out_next.ver_sample  = st_reg.vv ? six_tap(o_tap[0], o_tap[1], o_tap[2], o_tap[3],
                                                   o_tap[4], st_reg.pixel) : 8'd0;
        out_next.dia_valid   = st_reg.dv;
        out_next.dia_sample  = st_reg.dv ? six_tap(h_tap[0], h_tap[1], h_tap[2], h_tap[3],
                                                   h_tap[4], st_reg.hor) : 8'd0;
        out_next.window_last = st_reg.last;
    end

    hpi_ram #(
        .WIDTH(hpi_pkg::WORD_W),
        .DEPTH(hpi_pkg::MAX_WIDTH)
    ) u_orig_ram (
        .clk  (aclk),
        .we   (o_we),
        .waddr(o_waddr),
        .wdata(o_wdata),
        .re   (accept),
        .raddr(o_raddr),
        .rdata(o_rdata)
    );

    hpi_ram #(
        .WIDTH(hpi_pkg::WORD_W),
        .DEPTH(hpi_pkg::MAX_WIDTH)
    ) u_hor_ram (
        .clk  (aclk),
        .we   (h_we),
        .waddr(h_waddr),
        .wdata(h_wdata),
        .re   (accept),
        .raddr(h_raddr),
        .rdata(h_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_width_reg  <= 6'd32;
            window_height_reg <= 6'd32;
            hor_width_reg     <= 5'd27;
            hor_height_reg    <= 6'd32;
            ver_width_reg     <= 5'd27;
            ver_height_reg    <= 5'd27;
            dia_width_reg     <= 5'd27;
            dia_height_reg    <= 5'd27;
        end else if (cfg_write_en) begin
            case (cfg_index)
                hpi_pkg::CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                hpi_pkg::CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                hpi_pkg::CFG_HOR_WIDTH:     hor_width_reg     <= cfg_data[4:0];
                hpi_pkg::CFG_HOR_HEIGHT:    hor_height_reg    <= cfg_data;
                hpi_pkg::CFG_VER_WIDTH:     ver_width_reg     <= cfg_data[4:0];
                hpi_pkg::CFG_VER_HEIGHT:    ver_height_reg    <= cfg_data[4:0];
                hpi_pkg::CFG_DIA_WIDTH:     dia_width_reg     <= cfg_data[4:0];
                hpi_pkg::CFG_DIA_HEIGHT:    dia_height_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= 5'd0;
            col_pos_reg <= 5'd0;
            slot_reg    <= 3'd0;
            for (int k = 0; k < hpi_pkg::TAP_ROWS; k++) begin
                tap_reg[k] <= 8'd0;
            end
        end else if (accept) begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            slot_reg    <= slot_next;
            for (int k = 0; k < hpi_pkg::TAP_ROWS - 1; k++) begin
                tap_reg[k] <= tap_reg[k+1];
            end
            tap_reg[hpi_pkg::TAP_ROWS-1] <= s_data.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= st_next;
        end
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("Input stalled while the output register is empty.");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st_valid_reg)
        else $error("Accepted transaction did not reach the filter stage.");

    a_hor_valid_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.hor_valid |-> m_data_reg.in_col >= 5'd5)
        else $error("Horizontal sample flagged valid in the first five columns.");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.dia_valid |-> m_data_reg.dia_sample == 8'd0)
        else $error("Diagonal sample nonzero while flagged invalid.");

    a_dia_needs_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.dia_valid || m_data_reg.ver_valid)
        |-> m_data_reg.in_row >= 5'd5)
        else $error("Vertical or diagonal sample flagged valid in the first five rows.");

endmodule
